FILE: rtl/updc_pkg.sv
package updc_pkg;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_BYTE = 1'b1;

    localparam logic KIND_BODY    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam logic [1:0] VERDICT_GOOD     = 2'd0;
    localparam logic [1:0] VERDICT_CRC_ERR  = 2'd1;
    localparam logic [1:0] VERDICT_OVERFLOW = 2'd2;

    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [15:0] TIMER_MAX     = 16'hFFFF;

    // Contribution of each bit of (crc ^ byte) to the next CRC-8, polynomial 0x07.
    localparam logic [7:0] CRC_TERMS [8] = '{
        8'h07, 8'h0E, 8'h1C, 8'h38, 8'h70, 8'hE0, 8'hC7, 8'h89
    };

    typedef struct packed {
        logic        kind;
        logic [7:0]  body_byte;
        logic [5:0]  body_index;
        logic [7:0]  command;
        logic [15:0] body_length;
        logic [1:0]  verdict;
    } res_t;

    function automatic logic [7:0] crc8_add(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] x;
        logic [7:0] r;
        x = crc ^ b;
        r = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (x[i])
            begin
                r = r ^ CRC_TERMS[i];
            end
        end
        return r;
    endfunction

endpackage

FILE: rtl/updc_parser.sv
module updc_parser #(
    parameter int BUFFER_BYTES = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               opcode,
    input  logic [7:0]         rx_byte,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata,
    input  logic               buf_full,
    output logic               push,
    output updc_pkg::res_t     push_data
);
    import updc_pkg::*;

    localparam int SEEN_W = $clog2(BUFFER_BYTES + 1);

    logic              s1_valid_reg, s1_valid_next;
    logic              s1_op_reg;
    logic [7:0]        s1_byte_reg;
    logic [15:0]       timeout_reg;
    logic [SEEN_W-1:0] seen_reg, seen_next;
    logic [7:0]        cmd_reg, cmd_next;
    logic [15:0]       len_reg, len_next;
    logic [7:0]        crc_reg, crc_next;
    logic [15:0]       timer_reg, timer_next;

    logic              accept;
    logic              fire;
    logic              has_res;
    res_t              res;
    logic [SEEN_W-1:0] pos;
    logic [7:0]        crc_cur;
    logic [6:0]        pos_ext;

    assign in_stall = s1_valid_reg & buf_full;
    assign accept   = in_valid & ~in_stall;
    assign fire     = s1_valid_reg & ~buf_full;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        seen_next  = seen_reg;
        cmd_next   = cmd_reg;
        len_next   = len_reg;
        crc_next   = crc_reg;
        timer_next = timer_reg;
        has_res    = 1'b0;
        res        = '0;
        pos        = seen_reg;
        crc_cur    = crc_reg;
        pos_ext    = 7'(seen_reg);

        if (s1_op_reg == OP_TICK)
        begin
            if (timer_reg != TIMER_MAX)
            begin
                timer_next = timer_reg + 16'd1;
            end
        end
        else
        begin
            // A long gap drops the partial packet silently.
            if (timer_reg > timeout_reg)
            begin
                pos     = '0;
                crc_cur = 8'h00;
            end
            pos_ext    = 7'(pos);
            timer_next = 16'd0;

            if (32'(pos) >= BUFFER_BYTES)
            begin
                has_res          = 1'b1;
                res.kind         = KIND_VERDICT;
                res.command      = cmd_reg;
                res.body_length  = len_reg;
                res.verdict      = VERDICT_OVERFLOW;
                seen_next        = '0;
                crc_next         = 8'h00;
            end
            else
            begin
                seen_next = pos + SEEN_W'(1);
                crc_next  = crc8_add(crc_cur, s1_byte_reg);
                if (pos_ext == 7'd0)
                begin
                    cmd_next = s1_byte_reg;
                    len_next = 16'd0;
                end
                else if (pos_ext == 7'd1)
                begin
                    len_next = {s1_byte_reg, 8'h00};
                end
                else if (pos_ext == 7'd2)
                begin
                    len_next = {len_reg[15:8], s1_byte_reg};
                end
                else if (17'(pos_ext) < (17'(len_reg) + 17'd3))
                begin
                    has_res        = 1'b1;
                    res.kind       = KIND_BODY;
                    res.body_byte  = s1_byte_reg;
                    res.body_index = 6'(pos_ext - 7'd3);
                end
                else
                begin
                    has_res         = 1'b1;
                    res.kind        = KIND_VERDICT;
                    res.command     = cmd_reg;
                    res.body_length = len_reg;
                    res.verdict     = (s1_byte_reg == crc_cur) ? VERDICT_GOOD
                                                               : VERDICT_CRC_ERR;
                    seen_next       = '0;
                    crc_next        = 8'h00;
                end
            end
        end
    end

    assign push      = fire & has_res;
    assign push_data = res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            timeout_reg  <= TIMEOUT_RESET;
            seen_reg     <= '0;
            cmd_reg      <= 8'h00;
            len_reg      <= 16'd0;
            crc_reg      <= 8'h00;
            timer_reg    <= 16'd0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (cfg_we)
            begin
                timeout_reg <= cfg_wdata;
            end
            if (fire)
            begin
                seen_reg  <= seen_next;
                cmd_reg   <= cmd_next;
                len_reg   <= len_next;
                crc_reg   <= crc_next;
                timer_reg <= timer_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg   <= opcode;
            s1_byte_reg <= rx_byte;
        end
    end

endmodule

FILE: rtl/updc_outbuf.sv
module updc_outbuf (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  updc_pkg::res_t push_data,
    output logic           full,
    output logic           out_valid,
    input  logic           out_stall,
    output updc_pkg::res_t out_data
);
    import updc_pkg::*;

    res_t       mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign full      = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid & ~out_stall;
    assign out_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/uart_packet_deframer_crc8.sv
// Serial packet deframer with CRC-8 (polynomial 0x07, initial value 0). Each input beat is
// either a millisecond tick (opcode 0) or one received byte (opcode 1). Bytes are parsed as
// a command byte, a big-endian 16-bit body length, the body and a CRC-8 over everything
// before it. Every body byte leaves as a beat with kind 0 and its index within the body
// (modulo 64); the CRC byte yields a verdict beat with kind 1 (good or CRC mismatch) that
// carries the command and the length. A packet that would need more than BUFFER_BYTES bytes
// ends in an overflow verdict on the byte that does not fit, and that byte is dropped. When
// more than timeout_ms ticks pass between two bytes, the later byte starts a new packet and
// the dropped one gives no verdict. Rate: one input beat per clock cycle while in_stall is
// low. The beat is held in an input register, the CRC, counters and header fields are
// updated from it, and the result lands in a two-entry output queue that presents it on
// the outputs. The queue's registered full flag is the only thing that holds the input
// back, so a stalled output does not cost throughput until the queue fills. Ticks and
// header bytes produce no output beat. timeout_ms resets to 1000 and is written through
// cfg_we and cfg_wdata; the user must write it only while the block is idle, which the
// block itself does not enforce.
module uart_packet_deframer_crc8 #(
    parameter int BUFFER_BYTES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic [7:0]  body_byte,
    output logic [5:0]  body_index,
    output logic [7:0]  command,
    output logic [15:0] body_length,
    output logic [1:0]  verdict,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);
    import updc_pkg::*;

    logic buf_full;
    logic push;
    res_t push_data;
    res_t out_data;

    // Input register, parse state and the per-beat update.
    updc_parser #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .rx_byte   (rx_byte),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .buf_full  (buf_full),
        .push      (push),
        .push_data (push_data)
    );

    // Result queue that decouples the output handshake from the parser.
    updc_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign kind        = out_data.kind;
    assign body_byte   = out_data.body_byte;
    assign body_index  = out_data.body_index;
    assign command     = out_data.command;
    assign body_length = out_data.body_length;
    assign verdict     = out_data.verdict;

endmodule
